[src/scp_pkg.sv]
// ----------------------------------------------------------------------------
// Sine/cosine polynomial package
// Shared constants, coefficient tables and fixed-point helpers for the
// pipelined sine/cosine evaluator.
// ----------------------------------------------------------------------------
package scp_pkg;

	// Default formats
	localparam int ANGLE_WIDTH_DEF = 32;
	localparam int ANGLE_FRAC_DEF  = 24;
	localparam int RESULT_FRAC_DEF = 30;
	localparam int VALUE_WIDTH     = 32;

	// Function select codes
	localparam logic CMD_SINE   = 1'b0;
	localparam logic CMD_COSINE = 1'b1;

	// Internal polynomial format: Q.31 magnitude, 34-bit signed accumulators
	localparam int IFRAC    = 31;
	localparam int XW       = 31;
	localparam int PW       = 34;
	localparam int UW       = 34;
	localparam int HORNER_STEPS = 4;

	// pi scaled by 2^62
	localparam logic [63:0] PI_Q62 = 64'hC90F_DAA2_2168_C235;

	// round(pi * 2^e), valid for 1 <= e <= 61
	function automatic logic [63:0] pi_at(input int e);
		int          s;
		logic [64:0] t;
		s = 62 - e;
		t = {1'b0, PI_Q62} + (65'd1 << (s - 1));
		t = t >> s;
		return t[63:0];
	endfunction

	localparam logic [UW-1:0] PI_I         = UW'(pi_at(IFRAC));
	localparam logic [31:0]   HALF_PI_I    = 32'(pi_at(IFRAC - 1));
	localparam logic [31:0]   QUARTER_PI_I = 32'(pi_at(IFRAC - 2));

	localparam logic signed [PW-1:0] ONE_Q31 = 34'sd2147483648;

	// Horner coefficients, highest power first; the last entry is the
	// constant term of the inner polynomial
	localparam logic signed [PW-1:0] ODD_COEF [0:HORNER_STEPS] = '{
		34'sd5918,
		-34'sd426088,
		34'sd17895697,
		-34'sd357913941,
		34'sd2147483648
	};

	localparam logic signed [PW-1:0] EVEN_COEF [0:HORNER_STEPS] = '{
		-34'sd592,
		34'sd53261,
		-34'sd2982616,
		34'sd89478485,
		-34'sd1073741824
	};

	// Q.31 product, rounded to nearest with ties toward plus infinity
	function automatic logic signed [PW-1:0] qmul(
		input logic [XW-1:0] a,
		input logic signed [PW-1:0] b
	);
		logic signed [65:0] prod;
		prod = $signed({35'd0, a}) * 66'(b) + (66'sd1 <<< (IFRAC - 1));
		return prod[IFRAC+PW-1:IFRAC];
	endfunction

endpackage

[src/sine_cosine_polynomial.sv]
// ----------------------------------------------------------------------------
// Sine/cosine polynomial evaluator
// Pipeline: one range-reduction stage per quotient bit plus six multiplier
// stages of the polynomial; the default angle format is Q8.24.
// Throughput: one transaction per cycle; busy stays low, the receiver cannot
// stall. Reset clears every valid bit; payload registers are not reset.
// ----------------------------------------------------------------------------
module sine_cosine_polynomial
	import scp_pkg::*;
#(
	parameter int ANGLE_WIDTH = ANGLE_WIDTH_DEF,
	parameter int ANGLE_FRAC  = ANGLE_FRAC_DEF,
	parameter int RESULT_FRAC = RESULT_FRAC_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	output logic                          busy,
	input  logic                          cmd,
	input  logic signed [ANGLE_WIDTH-1:0] angle,
	output logic                          done,
	output logic signed [VALUE_WIDTH-1:0] value
);

	// Reduction geometry
	localparam int J  = ((ANGLE_WIDTH - ANGLE_FRAC) > 3 ?
		(ANGLE_WIDTH - ANGLE_FRAC) : 3) - 1;
	localparam int NW = ((ANGLE_WIDTH > ANGLE_FRAC + 3) ?
		ANGLE_WIDTH : (ANGLE_FRAC + 3)) + 3;
	localparam int RXW = ANGLE_FRAC + J + 5;
	localparam int RW  = ((RESULT_FRAC > IFRAC) ? RESULT_FRAC : IFRAC) + 4;

	localparam logic [63:0] TWO_PI_A  = pi_at(ANGLE_FRAC + 1);
	localparam logic [63:0] HALF_PI_A = pi_at(ANGLE_FRAC - 1);
	localparam logic [63:0] DEN       = TWO_PI_A << 1;

	localparam logic signed [RW-1:0] ONE_R = RW'(1) <<< RESULT_FRAC;

	// ------------------------------------------------------------------------
	// Entry: cosine offset, remainder numerator, bias to a nonnegative value
	// ------------------------------------------------------------------------
	logic signed [NW-1:0] a_ext;
	logic signed [NW-1:0] num;
	logic [RXW-1:0]       biased;

	assign busy   = 1'b0;
	assign a_ext  = NW'(angle) + ((cmd == CMD_COSINE) ? NW'(HALF_PI_A) : NW'(0));
	assign num    = (a_ext <<< 1) + NW'(TWO_PI_A);
	assign biased = RXW'(num) + (RXW'(DEN) << J);

	logic [RXW-1:0] red_s   [0:J+1];
	logic           red_v_s [0:J+1];

	always_ff @(posedge clk) begin
		red_s[0] <= biased;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			red_v_s[0] <= 1'b0;
		end else begin
			red_v_s[0] <= start;
		end
	end

	// ------------------------------------------------------------------------
	// Restoring remainder by 4*pi, one quotient bit per stage
	// ------------------------------------------------------------------------
	genvar gk;
	for (gk = 0; gk <= J; gk++) begin : g_reduce
		localparam logic [RXW-1:0] DIV_K = RXW'(DEN) << (J - gk);

		always_ff @(posedge clk) begin
			if (red_s[gk] >= DIV_K) begin
				red_s[gk+1] <= red_s[gk] - DIV_K;
			end else begin
				red_s[gk+1] <= red_s[gk];
			end
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				red_v_s[gk+1] <= 1'b0;
			end else begin
				red_v_s[gk+1] <= red_v_s[gk];
			end
		end
	end

	// ------------------------------------------------------------------------
	// Post 1: recover signed remainder, fold sign, scale to Q.31
	// ------------------------------------------------------------------------
	logic [ANGLE_FRAC+3:0]        rem_m;
	logic signed [ANGLE_FRAC+4:0] rem2;
	logic signed [ANGLE_FRAC+3:0] rem_r;
	logic signed [ANGLE_FRAC+3:0] rem_abs;
	logic [ANGLE_FRAC+1:0]        mag;
	logic [UW-1:0]                u_c;

	assign rem_m   = red_s[J+1][ANGLE_FRAC+3:0];
	assign rem2    = $signed({1'b0, rem_m}) - (ANGLE_FRAC + 5)'(TWO_PI_A);
	assign rem_r   = rem2[ANGLE_FRAC+4:1];
	assign rem_abs = rem2[ANGLE_FRAC+4] ? -rem_r : rem_r;
	assign mag     = rem_abs[ANGLE_FRAC+1:0];

	if (ANGLE_FRAC <= IFRAC) begin : g_up
		assign u_c = UW'(mag) << (IFRAC - ANGLE_FRAC);
	end else begin : g_down
		localparam int SH = ANGLE_FRAC - IFRAC;
		logic [ANGLE_FRAC+2:0] rnd;
		assign rnd = ({1'b0, mag} + ((ANGLE_FRAC + 3)'(1) << (SH - 1))) >> SH;
		assign u_c = UW'(rnd);
	end

	logic [UW-1:0] u_s1;
	logic          neg_s1;
	logic          v_s1;

	always_ff @(posedge clk) begin
		u_s1   <= u_c;
		neg_s1 <= rem2[ANGLE_FRAC+4];
	end

	// ------------------------------------------------------------------------
	// Post 2: clamp to pi, mirror into [0, pi/2]
	// ------------------------------------------------------------------------
	logic [UW-1:0] u_clamp;
	logic [UW-1:0] u_mir;
	logic [31:0]   um_s2;
	logic          neg_s2;
	logic          v_s2;

	assign u_clamp = (u_s1 > PI_I) ? PI_I : u_s1;
	assign u_mir   = (u_clamp > UW'(HALF_PI_I)) ? (PI_I - u_clamp) : u_clamp;

	always_ff @(posedge clk) begin
		um_s2  <= u_mir[31:0];
		neg_s2 <= neg_s1;
	end

	// ------------------------------------------------------------------------
	// Post 3: split at pi/4, pick polynomial and its argument
	// ------------------------------------------------------------------------
	logic          sel_odd;
	logic [31:0]   comp_arg;
	logic [XW-1:0] x_s3;
	logic          odd_s3;
	logic          neg_s3;
	logic          v_s3;

	assign sel_odd  = (um_s2 <= QUARTER_PI_I);
	assign comp_arg = HALF_PI_I - um_s2;

	always_ff @(posedge clk) begin
		x_s3   <= sel_odd ? um_s2[XW-1:0] : comp_arg[XW-1:0];
		odd_s3 <= sel_odd;
		neg_s3 <= neg_s2;
	end

	// ------------------------------------------------------------------------
	// Square the argument, load the leading coefficient
	// ------------------------------------------------------------------------
	logic [61:0] sq;

	assign sq = 62'(x_s3) * 62'(x_s3) + (62'd1 << (IFRAC - 1));

	logic [XW-1:0]        hx2_s  [0:HORNER_STEPS];
	logic [XW-1:0]        hx_s   [0:HORNER_STEPS];
	logic                 hodd_s [0:HORNER_STEPS];
	logic                 hneg_s [0:HORNER_STEPS];
	logic signed [PW-1:0] hp_s   [0:HORNER_STEPS];
	logic                 hv_s   [0:HORNER_STEPS];

	always_ff @(posedge clk) begin
		hx2_s[0]  <= sq[61:IFRAC];
		hx_s[0]   <= x_s3;
		hodd_s[0] <= odd_s3;
		hneg_s[0] <= neg_s3;
		hp_s[0]   <= odd_s3 ? ODD_COEF[0] : EVEN_COEF[0];
	end

	// ------------------------------------------------------------------------
	// Horner steps, one multiply per stage
	// ------------------------------------------------------------------------
	genvar gh;
	for (gh = 1; gh <= HORNER_STEPS; gh++) begin : g_horner
		always_ff @(posedge clk) begin
			hx2_s[gh]  <= hx2_s[gh-1];
			hx_s[gh]   <= hx_s[gh-1];
			hodd_s[gh] <= hodd_s[gh-1];
			hneg_s[gh] <= hneg_s[gh-1];
			hp_s[gh]   <= (hodd_s[gh-1] ? ODD_COEF[gh] : EVEN_COEF[gh]) +
				qmul(hx2_s[gh-1], hp_s[gh-1]);
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				hv_s[gh] <= 1'b0;
			end else begin
				hv_s[gh] <= hv_s[gh-1];
			end
		end
	end

	// ------------------------------------------------------------------------
	// Final multiply: x*p for sine, 1 + x^2*p for cosine
	// ------------------------------------------------------------------------
	logic [XW-1:0]        fin_op;
	logic signed [PW-1:0] fin_add;
	logic signed [PW-1:0] fin_s9;
	logic                 neg_s9;
	logic                 v_s9;

	assign fin_op  = hodd_s[HORNER_STEPS] ? hx_s[HORNER_STEPS] : hx2_s[HORNER_STEPS];
	assign fin_add = hodd_s[HORNER_STEPS] ? PW'(0) : ONE_Q31;

	always_ff @(posedge clk) begin
		fin_s9 <= fin_add + qmul(fin_op, hp_s[HORNER_STEPS]);
		neg_s9 <= hneg_s[HORNER_STEPS];
	end

	// ------------------------------------------------------------------------
	// Apply sign
	// ------------------------------------------------------------------------
	logic signed [PW-1:0] res_s10;
	logic                 v_s10;

	always_ff @(posedge clk) begin
		res_s10 <= neg_s9 ? -fin_s9 : fin_s9;
	end

	// ------------------------------------------------------------------------
	// Rescale to the result format and clamp to +-1.0
	// ------------------------------------------------------------------------
	logic signed [RW-1:0] scaled;
	logic signed [RW-1:0] clamped;

	if (RESULT_FRAC < IFRAC) begin : g_rdown
		localparam int RS = IFRAC - RESULT_FRAC;
		assign scaled = (RW'(res_s10) + (RW'(1) <<< (RS - 1))) >>> RS;
	end else begin : g_rup
		assign scaled = RW'(res_s10) <<< (RESULT_FRAC - IFRAC);
	end

	always_comb begin
		clamped = scaled;
		if (scaled > ONE_R) begin
			clamped = ONE_R;
		end else if (scaled < -ONE_R) begin
			clamped = -ONE_R;
		end
	end

	logic signed [VALUE_WIDTH-1:0] value_q;
	logic                          done_q;

	always_ff @(posedge clk) begin
		value_q <= clamped[VALUE_WIDTH-1:0];
	end

	// Advance valid bits through the fixed stages
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1    <= 1'b0;
			v_s2    <= 1'b0;
			v_s3    <= 1'b0;
			hv_s[0] <= 1'b0;
			v_s9    <= 1'b0;
			v_s10   <= 1'b0;
			done_q  <= 1'b0;
		end else begin
			v_s1    <= red_v_s[J+1];
			v_s2    <= v_s1;
			v_s3    <= v_s2;
			hv_s[0] <= v_s3;
			v_s9    <= hv_s[HORNER_STEPS];
			v_s10   <= v_s9;
			done_q  <= v_s10;
		end
	end

	assign done  = done_q;
	assign value = value_q;

endmodule
